// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the sector bitmap allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds whenever ante holds, at every rising clock edge out of reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
// Check that cond never holds at a rising clock edge out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== rtl/fsba_pkg.sv =====
// Shared constants, codes and types of the free sector bitmap allocator.
package fsba_pkg;

  // Disk geometry and map layout
  localparam int SECTORS   = 1760;
  localparam int MAP_WORDS = 55;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int WADDR_W   = $clog2(MAP_WORDS);
  localparam int SEC_W     = 12;
  localparam int OFF_W     = SEC_W + 1;

  // Sector 2 is bit 0 of word 0
  localparam int FIRST_SEC = 2;
  localparam int LAST_OFF  = SECTORS - FIRST_SEC;
  localparam int TRIES     = SECTORS - 4;
  localparam int MAP_BITS  = MAP_WORDS * WORD_W;
  localparam int END_OFF   = (LAST_OFF < MAP_BITS) ? LAST_OFF : MAP_BITS;

  localparam logic [SEC_W-1:0] SCAN_START_RST = SEC_W'(881);

  // Negated sum of an all-ones map: -(N * (2^32 - 1)) = N mod 2^32
  localparam logic [WORD_W-1:0] CLEAR_SUM = WORD_W'(MAP_WORDS);

  // Stream widths
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_USED  = 2'd2,
    ST_RANGE = 2'd3
  } stat_t;

  // Half-open range [lo, hi) of bit offsets (sector minus two)
  typedef struct packed {
    logic [OFF_W-1:0] lo;
    logic [OFF_W-1:0] hi;
  } rng_t;

  // Write request into the map store
  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } map_wr_t;

endpackage

// ===== rtl/fsba_map_ram.sv =====
// Bitmap word store with per-word valid bits; an unwritten word reads as all free.
module fsba_map_ram
  import fsba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [WADDR_W-1:0] rd_addr,
  input  map_wr_t            wr,
  input  logic               clr,
  output logic [WORD_W-1:0]  rd_word
);

  logic [WORD_W-1:0]    map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_r;
  logic [WORD_W-1:0]    rd_word_r;
  logic                 rd_vld_r;

  // Write one word, read one word with registered data
  always_ff @(posedge clk) begin
    if (wr.en) begin
      map_mem[wr.addr] <= wr.data;
    end
    rd_word_r <= map_mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  // Drop all valid bits on reset or clear, set on write
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_word = rd_vld_r ? rd_word_r : '1;

endmodule

// ===== rtl/fsba_bit_scan.sv =====
// Shared scan unit: masks one map word to an offset range and finds its lowest free bit.
module fsba_bit_scan
  import fsba_pkg::*;
(
  input  logic [WORD_W-1:0]  word,
  input  logic [WADDR_W-1:0] widx,
  input  rng_t               rng,
  output logic               hit,
  output logic [BIT_W-1:0]   hit_bit
);

  logic [OFF_W-1:0]  base;
  logic [OFF_W-1:0]  diff_l;
  logic [OFF_W-1:0]  diff_h;
  logic [WORD_W-1:0] mask_l;
  logic [WORD_W-1:0] mask_h;
  logic [WORD_W-1:0] cand;

  assign base   = OFF_W'({widx, {BIT_W{1'b0}}});
  assign diff_l = rng.lo - base;
  assign diff_h = rng.hi - base;

  // Keep bits at or above the range start
  always_comb begin
    if (rng.lo <= base) begin
      mask_l = '1;
    end else if (diff_l < OFF_W'(WORD_W)) begin
      mask_l = {WORD_W{1'b1}} << diff_l[BIT_W-1:0];
    end else begin
      mask_l = '0;
    end
  end

  // Keep bits below the range end
  always_comb begin
    if (rng.hi <= base) begin
      mask_h = '0;
    end else if (diff_h >= OFF_W'(WORD_W)) begin
      mask_h = '1;
    end else begin
      mask_h = (WORD_W'(1) << diff_h[BIT_W-1:0]) - WORD_W'(1);
    end
  end

  assign cand = word & mask_l & mask_h;
  assign hit  = |cand;

  // Lowest set bit wins
  always_comb begin
    hit_bit = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_bit = BIT_W'(i);
      end
    end
  end

endmodule

// ===== rtl/free_sector_bitmap_allocator.sv =====
// Free sector bitmap allocator: stream-in commands, one stream-out result per command.
//
// Input stream: in_tuser carries the command (allocate, mark used, query,
// clear all) and in_tdata the sector number. One command is worked on at a
// time; in_tready is high only while the block is idle.
// Output stream: one transfer per command with the allocated sector, the
// in-use flag, the status and the bitmap checksum after the command.
// Config: cfg_data sets the sector where an allocation scan begins; it is
// always ready; the user writes it only while no command is in flight (not enforced).
// Flow: clear all and out-of-range commands go from idle straight to the
// result state; mark used and query pass through setup and a one-word scan.
// Allocate reads one map word per cycle through the shared scan unit,
// visiting at most MAP_WORDS + 1 words; the one read port of the word
// store and the one scan unit set that rate.
// Reset: every sector free, checksum equal to MAP_WORDS, scan start 881;
// no clearing pass is needed since per-word valid bits cover the map.
// Stall: a finished result waits in the output register while the next
// command is accepted; a second result waits in the sequencer until the
// output register is taken.
`include "assert_macros.svh"

module free_sector_bitmap_allocator
  import fsba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [11:0] sector, [15:12] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: [1:0] command
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: [11:0] sector_out, [12] in_use, [14:13] status,
  // [46:15] map_checksum, [47] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [SEC_W-1:0]      cfg_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_PUT
  } state_t;

  state_t              state_r, state_nxt;
  logic                iss_on_r, iss_on_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [WORD_W-1:0]   sum_r, sum_nxt;
  logic [SEC_W-1:0]    scan_start_r, scan_start_nxt;

  cmd_t                cmd_r, cmd_nxt;
  rng_t                rng0_r, rng0_nxt;
  rng_t                rng1_r, rng1_nxt;
  logic [WADDR_W-1:0]  iss_w_r, iss_w_nxt;
  logic                iss_ph_r, iss_ph_nxt;
  logic [WADDR_W-1:0]  chk_w_r, chk_w_nxt;
  logic                chk_ph_r, chk_ph_nxt;
  logic                chk_last_r, chk_last_nxt;
  logic [SEC_W-1:0]    res_sec_r, res_sec_nxt;
  logic                res_use_r, res_use_nxt;
  stat_t               res_st_r, res_st_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                in_acc;
  cmd_t                in_cmd;
  logic [OFF_W-1:0]    sec_ext;
  logic [OFF_W-1:0]    sec_off;
  logic                sec_ok;
  logic [OFF_W-1:0]    ss_ext;
  logic [OFF_W-1:0]    start_sec;
  logic [OFF_W-1:0]    start_off;
  logic [OFF_W-1:0]    span;
  logic [OFF_W-1:0]    tail;
  rng_t                alloc_rng0;
  rng_t                alloc_rng1;
  logic                rng0_ne;
  logic                rng1_ne;
  rng_t                iss_rng;
  logic [OFF_W-1:0]    iss_end;
  logic                iss_last_w;
  rng_t                chk_rng;
  logic [WORD_W-1:0]   map_word;
  logic                hit;
  logic [BIT_W-1:0]    hit_bit;
  logic [WORD_W-1:0]   hit_mask;
  map_wr_t             map_wr;
  logic                map_clr;

  assign in_acc    = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tuser[1:0]);
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Decode the target sector of mark used and query
  assign sec_ext = OFF_W'(in_tdata[SEC_W-1:0]);
  assign sec_off = sec_ext - OFF_W'(FIRST_SEC);
  assign sec_ok  = (sec_ext >= OFF_W'(FIRST_SEC)) && (sec_ext < OFF_W'(SECTORS)) &&
                   ((sec_off >> BIT_W) < OFF_W'(MAP_WORDS));

  // Split the wrapping allocation scan into a head range and a wrapped tail range
  assign ss_ext    = OFF_W'(scan_start_r);
  assign start_sec = ((ss_ext >= OFF_W'(SECTORS)) || (ss_ext < OFF_W'(FIRST_SEC))) ?
                     OFF_W'(FIRST_SEC) : ss_ext;
  assign start_off = start_sec - OFF_W'(FIRST_SEC);
  assign span      = start_off + OFF_W'(TRIES);
  assign tail      = (span > OFF_W'(LAST_OFF)) ? (span - OFF_W'(LAST_OFF)) : '0;

  always_comb begin
    alloc_rng0.lo = start_off;
    alloc_rng0.hi = (span < OFF_W'(END_OFF)) ? span : OFF_W'(END_OFF);
    alloc_rng1.lo = '0;
    alloc_rng1.hi = (tail < OFF_W'(END_OFF)) ? tail : OFF_W'(END_OFF);
  end

  assign rng0_ne = (rng0_r.lo < rng0_r.hi);
  assign rng1_ne = (rng1_r.lo < rng1_r.hi);

  // Last word of the range being issued
  assign iss_rng    = iss_ph_r ? rng1_r : rng0_r;
  assign iss_end    = iss_rng.hi - OFF_W'(1);
  assign iss_last_w = (iss_w_r == iss_end[BIT_W +: WADDR_W]);

  assign chk_rng  = chk_ph_r ? rng1_r : rng0_r;
  assign hit_mask = WORD_W'(1) << hit_bit;

  fsba_map_ram u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (iss_w_r),
    .wr      (map_wr),
    .clr     (map_clr),
    .rd_word (map_word)
  );

  fsba_bit_scan u_scan (
    .word    (map_word),
    .widx    (chk_w_r),
    .rng     (chk_rng),
    .hit     (hit),
    .hit_bit (hit_bit)
  );

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    iss_on_nxt     = iss_on_r;
    chk_vld_nxt    = chk_vld_r;
    out_tvalid_nxt = out_tvalid_r;
    sum_nxt        = sum_r;
    scan_start_nxt = scan_start_r;
    cmd_nxt        = cmd_r;
    rng0_nxt       = rng0_r;
    rng1_nxt       = rng1_r;
    iss_w_nxt      = iss_w_r;
    iss_ph_nxt     = iss_ph_r;
    chk_w_nxt      = chk_w_r;
    chk_ph_nxt     = chk_ph_r;
    chk_last_nxt   = chk_last_r;
    res_sec_nxt    = res_sec_r;
    res_use_nxt    = res_use_r;
    res_st_nxt     = res_st_r;
    out_tdata_nxt  = out_tdata_r;
    map_wr         = '0;
    map_clr        = 1'b0;

    if (cfg_valid) begin
      scan_start_nxt = cfg_data;
    end

    // Free the output register once the transfer completes
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt     = in_cmd;
          res_sec_nxt = '0;
          res_use_nxt = 1'b0;
          res_st_nxt  = ST_OK;
          unique case (in_cmd)
            CMD_ALLOC: begin
              rng0_nxt  = alloc_rng0;
              rng1_nxt  = alloc_rng1;
              state_nxt = S_SETUP;
            end
            CMD_MARK, CMD_QUERY: begin
              if (sec_ok) begin
                rng0_nxt.lo = sec_off;
                rng0_nxt.hi = sec_off + OFF_W'(1);
                rng1_nxt    = '0;
                state_nxt   = S_SETUP;
              end else begin
                res_st_nxt = ST_RANGE;
                state_nxt  = S_PUT;
              end
            end
            CMD_CLEAR: begin
              map_clr   = 1'b1;
              sum_nxt   = CLEAR_SUM;
              state_nxt = S_PUT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SETUP: begin
        priority if (rng0_ne) begin
          iss_w_nxt  = rng0_r.lo[BIT_W +: WADDR_W];
          iss_ph_nxt = 1'b0;
          iss_on_nxt = 1'b1;
          state_nxt  = S_SCAN;
        end else if (rng1_ne) begin
          iss_w_nxt  = rng1_r.lo[BIT_W +: WADDR_W];
          iss_ph_nxt = 1'b1;
          iss_on_nxt = 1'b1;
          state_nxt  = S_SCAN;
        end else begin
          res_st_nxt = ST_FULL;
          state_nxt  = S_PUT;
        end
      end

      S_SCAN: begin
        // Issue one word read per cycle, advancing through head then tail range
        chk_vld_nxt  = iss_on_r;
        chk_w_nxt    = iss_w_r;
        chk_ph_nxt   = iss_ph_r;
        chk_last_nxt = iss_last_w && (iss_ph_r || !rng1_ne);
        if (iss_on_r) begin
          priority if (!iss_last_w) begin
            iss_w_nxt = iss_w_r + WADDR_W'(1);
          end else if (!iss_ph_r && rng1_ne) begin
            iss_w_nxt  = rng1_r.lo[BIT_W +: WADDR_W];
            iss_ph_nxt = 1'b1;
          end else begin
            iss_on_nxt = 1'b0;
          end
        end

        // Check the word read last cycle; stop on a hit or after the last word
        if (chk_vld_r && (hit || chk_last_r)) begin
          iss_on_nxt  = 1'b0;
          chk_vld_nxt = 1'b0;
          state_nxt   = S_PUT;
          unique case (cmd_r)
            CMD_ALLOC: begin
              if (hit) begin
                map_wr.en   = 1'b1;
                map_wr.addr = chk_w_r;
                map_wr.data = map_word & ~hit_mask;
                sum_nxt     = sum_r + hit_mask;
                res_sec_nxt = SEC_W'({chk_w_r, hit_bit}) + SEC_W'(FIRST_SEC);
              end else begin
                res_st_nxt = ST_FULL;
              end
            end
            CMD_MARK: begin
              if (hit) begin
                map_wr.en   = 1'b1;
                map_wr.addr = chk_w_r;
                map_wr.data = map_word & ~hit_mask;
                sum_nxt     = sum_r + hit_mask;
              end else begin
                res_st_nxt = ST_USED;
              end
            end
            CMD_QUERY: begin
              res_use_nxt = !hit;
            end
            default: begin
              res_st_nxt = ST_OK;
            end
          endcase
        end
      end

      S_PUT: begin
        // Hand the result to the output register once it is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {1'b0, sum_r, res_st_r, res_use_r, res_sec_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and result registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    rng0_r      <= rng0_nxt;
    rng1_r      <= rng1_nxt;
    iss_w_r     <= iss_w_nxt;
    iss_ph_r    <= iss_ph_nxt;
    chk_w_r     <= chk_w_nxt;
    chk_ph_r    <= chk_ph_nxt;
    chk_last_r  <= chk_last_nxt;
    res_sec_r   <= res_sec_nxt;
    res_use_r   <= res_use_nxt;
    res_st_r    <= res_st_nxt;
    out_tdata_r <= out_tdata_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      iss_on_r     <= 1'b0;
      chk_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
      sum_r        <= CLEAR_SUM;
      scan_start_r <= SCAN_START_RST;
    end else begin
      state_r      <= state_nxt;
      iss_on_r     <= iss_on_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      sum_r        <= sum_nxt;
      scan_start_r <= scan_start_nxt;
    end
  end

  // A pending word check only exists while scanning
  `ASSERT_IMPLY(a_chk_in_scan, clk, rst_n, chk_vld_r, state_r == S_SCAN)
  // The map is written only by an allocate or mark used that found a free bit
  `ASSERT_IMPLY(a_wr_cmd, clk, rst_n, map_wr.en, (state_r == S_SCAN) && (cmd_r == CMD_ALLOC || cmd_r == CMD_MARK))
  // A disk full result never carries a sector
  `ASSERT_IMPLY(a_full_no_sec, clk, rst_n, out_tvalid_r && (out_tdata_r[14:13] == ST_FULL), out_tdata_r[11:0] == '0)
  // An in-use answer comes with status ok and no sector
  `ASSERT_IMPLY(a_use_ok, clk, rst_n, out_tvalid_r && out_tdata_r[12], (out_tdata_r[14:13] == ST_OK) && (out_tdata_r[11:0] == '0))

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench of the free sector bitmap allocator, with a shadow bitmap scoreboard.
`timescale 1ns / 100ps

module testbench
  import fsba_pkg::*;
();

  // One result transfer as packed on out_tdata, highest bits first
  typedef struct packed {
    logic              pad;
    logic [WORD_W-1:0] map_checksum;
    stat_t             status;
    logic              in_use;
    logic [SEC_W-1:0]  sector_out;
  } alloc_result_t;

  // Shadow copy of the free map; owes one result per accepted command
  class sector_map_shadow;
    logic [WORD_W-1:0] map_word [MAP_WORDS];
    logic [SEC_W-1:0]  scan_from;
    logic [WORD_W-1:0] checksum;
    alloc_result_t     results_owed [$];
    int                mismatches;

    function new();
      set_all_free();
      refresh_checksum();
      scan_from  = SCAN_START_RST;
      mismatches = 0;
    endfunction

    function void set_all_free();
      foreach (map_word[i]) map_word[i] = '1;
    endfunction

    function void refresh_checksum();
      logic [WORD_W-1:0] total;
      total = '0;
      foreach (map_word[i]) total += map_word[i];
      checksum = -total;
    endfunction

    function bit in_map(int s);
      return s >= FIRST_SEC && s < SECTORS && ((s - FIRST_SEC) / WORD_W) < MAP_WORDS;
    endfunction

    function bit is_free(int s);
      if (!in_map(s)) return 1'b0;
      return map_word[(s - FIRST_SEC) / WORD_W][(s - FIRST_SEC) % WORD_W];
    endfunction

    function void take(int s);
      map_word[(s - FIRST_SEC) / WORD_W][(s - FIRST_SEC) % WORD_W] = 1'b0;
    endfunction

    // Apply one accepted command to the shadow map and queue its result
    function void accept_command(cmd_t cmd, logic [SEC_W-1:0] sector);
      alloc_result_t r;
      int s;
      int tries;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_ALLOC: begin
          s = scan_from;
          tries = TRIES;
          r.status = ST_FULL;
          // Wrap to the first sector before each candidate
          while (tries > 0) begin
            if (s >= SECTORS || s < FIRST_SEC) s = FIRST_SEC;
            if (is_free(s)) begin
              take(s);
              r.sector_out = SEC_W'(s);
              r.status = ST_OK;
              break;
            end
            s++;
            tries--;
          end
        end
        CMD_MARK: begin
          if (!in_map(sector)) r.status = ST_RANGE;
          else if (!is_free(sector)) r.status = ST_USED;
          else take(sector);
        end
        CMD_QUERY: begin
          if (!in_map(sector)) r.status = ST_RANGE;
          else r.in_use = !is_free(sector);
        end
        default: begin
          set_all_free();
        end
      endcase
      refresh_checksum();
      r.map_checksum = checksum;
      results_owed = {results_owed, r};
    endfunction

    // Compare one result transfer with the oldest owed result
    function void compare_result(logic [OUT_DATA_W-1:0] data);
      alloc_result_t got;
      alloc_result_t want;
      got = alloc_result_t'(data);
      if (results_owed.size() == 0) begin
        $error("result with no command outstanding: out_tdata %h", data);
        mismatches++;
        return;
      end
      want = results_owed.pop_front();
      if (got.sector_out !== want.sector_out) begin
        $error("sector_out: expected %0d, actual %0d", want.sector_out, got.sector_out);
        mismatches++;
      end
      if (got.in_use !== want.in_use) begin
        $error("in_use: expected %0d, actual %0d", want.in_use, got.in_use);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.map_checksum !== want.map_checksum) begin
        $error("map_checksum: expected %h, actual %h", want.map_checksum, got.map_checksum);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [SEC_W-1:0]      cfg_data;
  logic                  cfg_valid;
  logic                  cfg_ready;

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_request;

  sector_map_shadow shadow;

  free_sector_bitmap_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always #5 clk = ~clk;

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.compare_result(out_tdata);
  end

  // Drive out_tready: random stall bursts, plus one long hold on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = 400;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one command and hold it until transfer, then maybe idle a burst
  task automatic send_command(cmd_t cmd, logic [SEC_W-1:0] sector);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_DATA_W'(sector);
    do @(posedge clk); while (!in_tready);
    shadow.accept_command(cmd, sector);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop the input and wait until every owed result has come
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (shadow.results_owed.size() != 0 && waited < 50000) begin
      @(negedge clk);
      waited++;
    end
  endtask

  // Write scan_start while the block is idle
  task automatic write_scan_start(logic [SEC_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow.scan_from = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic cmd_t pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CMD_ALLOC;
    if (r < 65) return CMD_MARK;
    if (r < 97) return CMD_QUERY;
    return CMD_CLEAR;
  endfunction

  // Mostly sectors inside the map, sometimes any 12-bit value
  function automatic logic [SEC_W-1:0] pick_sector();
    if ($urandom_range(0, 4) == 0) return SEC_W'($urandom_range(0, 4095));
    return SEC_W'($urandom_range(FIRST_SEC, SECTORS - 1));
  endfunction

  task automatic run_mixed(int count);
    for (int i = 0; i < count; i++) send_command(pick_command(), pick_sector());
  endtask

  // Main sequence
  initial begin
    int i;
    int n;
    int r;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_ALLOC;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_request = 1'b0;
    shadow = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every command, range and already-used cases
    send_command(CMD_QUERY, 12'd2);
    send_command(CMD_ALLOC, 12'd0);
    send_command(CMD_QUERY, 12'd881);
    send_command(CMD_MARK, 12'd881);
    send_command(CMD_MARK, 12'd2);
    send_command(CMD_MARK, SEC_W'(SECTORS - 1));
    send_command(CMD_MARK, SEC_W'(SECTORS));
    send_command(CMD_MARK, 12'd0);
    send_command(CMD_MARK, 12'd1);
    send_command(CMD_QUERY, 12'hFFF);
    send_command(CMD_QUERY, SEC_W'(SECTORS - 1));
    send_command(CMD_MARK, 12'hAAA);
    send_command(CMD_QUERY, 12'h555);
    send_command(CMD_ALLOC, 12'hFFF);
    send_command(CMD_CLEAR, 12'd1234);
    send_command(CMD_QUERY, 12'd881);

    // Directed: scan start at zero and at one (below two), past the end, at the last
    write_scan_start(12'd0);
    send_command(CMD_ALLOC, 12'd0);
    send_command(CMD_ALLOC, 12'd0);
    write_scan_start(12'd1);
    send_command(CMD_ALLOC, 12'd0);
    write_scan_start(12'hFFF);
    send_command(CMD_ALLOC, 12'd0);
    write_scan_start(SEC_W'(SECTORS - 1));
    send_command(CMD_ALLOC, 12'd0);
    send_command(CMD_ALLOC, 12'd0);

    // Mixed traffic with one long output hold and one full drain
    write_scan_start(SEC_W'($urandom_range(0, 4095)));
    for (i = 0; i < 200; i++) begin
      if (i == 80) hold_request = 1'b1;
      tx_idle_on = !(i >= 80 && i < 120);
      if (i == 150) drain();
      send_command(pick_command(), pick_sector());
    end
    tx_idle_on = 1'b1;

    // Fill a large part of the disk with allocations so scans run long
    write_scan_start(SEC_W'($urandom_range(FIRST_SEC, SECTORS - 1)));
    send_command(CMD_CLEAR, pick_sector());
    for (i = 0; i < 700; i++) begin
      r = $urandom_range(0, 99);
      if (r < 88) send_command(CMD_ALLOC, pick_sector());
      else if (r < 95) send_command(CMD_QUERY, pick_sector());
      else send_command(CMD_MARK, pick_sector());
    end
    // Crowded map: marks often hit used sectors, queries often see them used
    for (i = 0; i < 20; i++) begin
      send_command(($urandom_range(0, 1) != 0) ? CMD_MARK : CMD_QUERY, pick_sector());
    end

    // Crowded map: mixed traffic with scan start past the end, then at the last sector
    write_scan_start(12'hFFF);
    run_mixed(100);
    write_scan_start(SEC_W'(SECTORS - 1));
    run_mixed(40);

    // Last part: no idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    write_scan_start(12'd2);
    run_mixed(150);

    drain();
    repeat (64) @(posedge clk);
    n = shadow.results_owed.size();
    if (n != 0) begin
      $error("%0d results never arrived", n);
      shadow.mismatches += n;
    end
    if (shadow.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fsba_pkg.sv
rtl/fsba_map_ram.sv
rtl/fsba_bit_scan.sv
rtl/free_sector_bitmap_allocator.sv
verif/testbench.sv
